### rtl/mutf8_pkg.sv
// Shared constants and types for the modified UTF-8 string decoder.
// No dependencies; used by every module under rtl/.
package mutf8_pkg;

  localparam int LENGTH_BITS_DEF = 32;

  // Decoder phases.
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_BODY   = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  // The length header is at most five bytes long.
  localparam logic [2:0] HDR_LAST_SHIFT = 3'd4;

  // Remaining bytes of a multi-byte sequence.
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;
  localparam logic [5:0]  LOW_SURR_TAG  = 6'b110111;
  localparam logic [20:0] SUPP_BASE     = 21'h10000;

  typedef struct packed {
    logic [20:0] code_point;
    logic        last_char;
    logic        empty_string;
    logic        bad_pair;
  } result_t;

  typedef struct packed {
    logic unit_done;  // a UTF-16 unit completed; count goes down by one
    logic emit;       // a result is produced by this byte
  } body_ctl_t;

endpackage

### rtl/mutf8_hdr.sv
// ULEB128 length header step: folds one byte into the unit count.
// Depends on mutf8_pkg.
module mutf8_hdr #(
  parameter int LENGTH_BITS = mutf8_pkg::LENGTH_BITS_DEF
) (
  input  logic [7:0]             data_byte,
  input  logic [LENGTH_BITS-1:0] count,
  input  logic [2:0]             shift,
  output logic [LENGTH_BITS-1:0] count_nxt,
  output logic [2:0]             shift_nxt,
  output logic                   hdr_done,
  output logic                   hdr_empty
);

  logic [5:0]  sh_amt;
  logic [34:0] field;
  logic        more;

  assign sh_amt    = 6'(shift) * 6'd7;
  assign field     = 35'(data_byte[6:0]) << sh_amt;
  assign count_nxt = count | field[LENGTH_BITS-1:0];
  // The fifth byte ends the header whatever its continuation bit says.
  assign more      = data_byte[7] && (shift < mutf8_pkg::HDR_LAST_SHIFT);
  assign shift_nxt = more ? shift + 3'd1 : shift;
  assign hdr_done  = !more;
  assign hdr_empty = !more && (count_nxt == '0);

endmodule

### rtl/mutf8_body.sv
// Body step: assembles modified UTF-8 sequences into UTF-16 units and
// joins surrogate pairs into code points. Depends on mutf8_pkg.
module mutf8_body (
  input  logic                  [7:0]  data_byte,
  input  logic                  [1:0]  pending,
  input  logic                  [15:0] accum,
  input  logic                  [9:0]  high_half,
  input  logic                         high_pending,
  input  logic                         last_unit,
  output logic                  [1:0]  pending_nxt,
  output logic                  [15:0] accum_nxt,
  output logic                  [9:0]  high_half_nxt,
  output logic                         high_pending_nxt,
  output mutf8_pkg::body_ctl_t         ctl,
  output mutf8_pkg::result_t           result
);

  logic        have_unit;
  logic [15:0] unit;

  always_comb begin
    pending_nxt = pending;
    accum_nxt   = accum;
    have_unit   = 1'b0;
    unit        = accum | 16'(data_byte[5:0]);
    case (pending)
      mutf8_pkg::PEND_NONE: begin
        if (data_byte != 8'd0 && !data_byte[7]) begin
          have_unit = 1'b1;
          unit      = 16'(data_byte);
        end else if (data_byte[7:5] == 3'b110) begin
          accum_nxt   = {5'd0, data_byte[4:0], 6'd0};
          pending_nxt = mutf8_pkg::PEND_ONE;
        end else begin
          accum_nxt   = {data_byte[3:0], 12'd0};
          pending_nxt = mutf8_pkg::PEND_TWO;
        end
      end
      mutf8_pkg::PEND_TWO: begin
        accum_nxt   = accum | {4'd0, data_byte[5:0], 6'd0};
        pending_nxt = mutf8_pkg::PEND_ONE;
      end
      default: begin
        pending_nxt = mutf8_pkg::PEND_NONE;
        have_unit   = 1'b1;
      end
    endcase
  end

  always_comb begin
    high_half_nxt       = high_half;
    high_pending_nxt    = high_pending;
    ctl.unit_done       = have_unit;
    ctl.emit            = 1'b0;
    result.code_point   = 21'(unit);
    result.last_char    = last_unit;
    result.empty_string = 1'b0;
    result.bad_pair     = 1'b0;
    if (have_unit) begin
      if (high_pending) begin
        high_pending_nxt  = 1'b0;
        ctl.emit          = 1'b1;
        result.code_point = mutf8_pkg::SUPP_BASE + 21'({high_half, unit[9:0]});
        result.bad_pair   = (unit[15:10] != mutf8_pkg::LOW_SURR_TAG);
      end else if (unit[15:10] == mutf8_pkg::HIGH_SURR_TAG) begin
        // A high surrogate that ends the string goes out alone, flagged.
        if (last_unit) begin
          ctl.emit        = 1'b1;
          result.bad_pair = 1'b1;
        end else begin
          high_half_nxt    = unit[9:0];
          high_pending_nxt = 1'b1;
        end
      end else begin
        ctl.emit = 1'b1;
      end
    end
  end

endmodule

### rtl/mutf8_string_decoder.sv
// Top level of the modified UTF-8 string decoder.
// Depends on mutf8_pkg, mutf8_hdr and mutf8_body.
//
// The decoder takes one byte of a string-data entry per transfer: first the
// ULEB128 count of UTF-16 units, then the modified UTF-8 body. It accepts one
// byte every clock cycle while in_ready is high; each byte updates the decoder
// state in the cycle it is accepted, and any resulting code point appears in
// the result register on the next cycle. in_ready drops only while a result
// waits in that register and out_ready is low. A byte with in_start_string
// high clears the phase, count, shift and pending state before it is used. A
// zero count yields one result with out_empty_string set; bytes after the last
// unit produce nothing until the next start.
module mutf8_string_decoder #(
  parameter int LENGTH_BITS = mutf8_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_string,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_code_point,
  output logic        out_last_char,
  output logic        out_empty_string,
  output logic        out_bad_pair
);

  logic [1:0]             phase_r, phase_nxt, phase_cur;
  logic [LENGTH_BITS-1:0] count_r, count_nxt, count_cur, hdr_count;
  logic [2:0]             shift_r, shift_nxt, shift_cur, hdr_shift;
  logic [1:0]             pending_r, pending_nxt, pending_cur, body_pending;
  logic [15:0]            accum_r, accum_nxt, body_accum;
  logic [9:0]             high_half_r, high_half_nxt, body_high_half;
  logic                   high_pending_r, high_pending_nxt, high_pending_cur;
  logic                   body_high_pending;
  logic                   hdr_done, hdr_empty, accept, emit;
  mutf8_pkg::body_ctl_t   body_ctl;
  mutf8_pkg::result_t     body_result, result, out_r;
  logic                   out_valid_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // A start byte sees the reset state.
  assign phase_cur        = in_start_string ? mutf8_pkg::PH_HEADER : phase_r;
  assign count_cur        = in_start_string ? '0 : count_r;
  assign shift_cur        = in_start_string ? 3'd0 : shift_r;
  assign pending_cur      = in_start_string ? mutf8_pkg::PEND_NONE : pending_r;
  assign high_pending_cur = in_start_string ? 1'b0 : high_pending_r;

  mutf8_hdr #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_hdr (
    .data_byte (in_data_byte),
    .count     (count_cur),
    .shift     (shift_cur),
    .count_nxt (hdr_count),
    .shift_nxt (hdr_shift),
    .hdr_done  (hdr_done),
    .hdr_empty (hdr_empty)
  );

  mutf8_body u_body (
    .data_byte        (in_data_byte),
    .pending          (pending_cur),
    .accum            (accum_r),
    .high_half        (high_half_r),
    .high_pending     (high_pending_cur),
    .last_unit        (count_cur == LENGTH_BITS'(1)),
    .pending_nxt      (body_pending),
    .accum_nxt        (body_accum),
    .high_half_nxt    (body_high_half),
    .high_pending_nxt (body_high_pending),
    .ctl              (body_ctl),
    .result           (body_result)
  );

  always_comb begin
    phase_nxt           = phase_cur;
    count_nxt           = count_cur;
    shift_nxt           = shift_cur;
    pending_nxt         = pending_cur;
    accum_nxt           = accum_r;
    high_half_nxt       = high_half_r;
    high_pending_nxt    = high_pending_cur;
    emit                = 1'b0;
    result              = body_result;
    case (phase_cur)
      mutf8_pkg::PH_HEADER: begin
        count_nxt = hdr_count;
        shift_nxt = hdr_shift;
        if (hdr_empty) begin
          phase_nxt           = mutf8_pkg::PH_DONE;
          emit                = 1'b1;
          result.code_point   = 21'd0;
          result.last_char    = 1'b1;
          result.empty_string = 1'b1;
          result.bad_pair     = 1'b0;
        end else if (hdr_done) begin
          phase_nxt = mutf8_pkg::PH_BODY;
        end
      end
      mutf8_pkg::PH_BODY: begin
        pending_nxt      = body_pending;
        accum_nxt        = body_accum;
        high_half_nxt    = body_high_half;
        high_pending_nxt = body_high_pending;
        emit             = body_ctl.emit;
        if (body_ctl.unit_done) begin
          count_nxt = count_cur - LENGTH_BITS'(1);
          if (count_cur == LENGTH_BITS'(1)) begin
            phase_nxt = mutf8_pkg::PH_DONE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= mutf8_pkg::PH_HEADER;
      count_r        <= '0;
      shift_r        <= 3'd0;
      pending_r      <= mutf8_pkg::PEND_NONE;
      high_pending_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (accept) begin
        phase_r        <= phase_nxt;
        count_r        <= count_nxt;
        shift_r        <= shift_nxt;
        pending_r      <= pending_nxt;
        high_pending_r <= high_pending_nxt;
      end
      if (accept && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      accum_r     <= accum_nxt;
      high_half_r <= high_half_nxt;
    end
    if (accept && emit) begin
      out_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_code_point   = out_r.code_point;
  assign out_last_char    = out_r.last_char;
  assign out_empty_string = out_r.empty_string;
  assign out_bad_pair     = out_r.bad_pair;

endmodule
